### design/enacc_pkg.sv
`default_nettype none
package enacc_pkg;

    localparam int DW = 64;
    localparam int MUL_STEPS = 3;
    localparam int SQRT_STEPS = 53;

    localparam logic [63:0] QNAN_BITS = 64'h7FF8_0000_0000_0000;
    localparam logic [63:0] INF_BITS  = 64'h7FF0_0000_0000_0000;
    localparam logic [10:0] EXP_ALL1  = 11'h7FF;

    // partial product select for the square
    localparam logic [1:0] MUL_LL = 2'd0;
    localparam logic [1:0] MUL_HL = 2'd1;
    localparam logic [1:0] MUL_HH = 2'd2;

    typedef struct packed {
        logic       load_elem;
        logic       norm_step;
        logic       mul_step;
        logic [1:0] mul_sel;
        logic       mul_round;
        logic       add_op;
        logic       add_round;
        logic       sqrt_load;
        logic       sqrt_init;
        logic       sqrt_step;
        logic       out_write;
    } enacc_cmd_t;

    typedef struct packed {
        logic man_norm;
        logic spec;
        logic out_busy;
    } enacc_stat_t;

endpackage
`default_nettype wire

### design/euclidean_norm_accumulator.sv
// element request: normalize check, three 27x27 partial products, product round, align-add,
// sum round, plus one normalize shift per leading zero of a subnormal element; a zero,
// infinite or nan element skips the multiply and product round; a last request then adds the
// 53-step root recurrence, plus one normalize shift per leading zero of a subnormal sum, or skips
// it for a zero, infinite or nan sum, plus any stall while the previous result waits in the output register
// reset: synchronous active-low aresetn clears the sum to +0.0 and drops m_tvalid
`default_nettype none
module euclidean_norm_accumulator (
    input  wire                          aclk,
    input  wire                          aresetn,
    // input requests
    input  wire                          s_tvalid,
    output logic                         s_tready,
    input  wire  [enacc_pkg::DW-1:0]     s_tdata,   // element_bits[63:0]
    input  wire                          s_tlast,   // last_element
    input  wire  [0:0]                   s_tuser,   // no_element
    // result requests
    output logic                         m_tvalid,
    input  wire                          m_tready,
    output logic [enacc_pkg::DW-1:0]     m_tdata    // norm_bits[63:0]
);
    import enacc_pkg::*;

    enacc_cmd_t  cmd;
    enacc_stat_t stat;

    // sequencer: walks square, add and root steps
    enacc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_none   (s_tuser[0]),
        .s_tready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    // arithmetic: multiplier, aligner/adder, root recurrence, output register
    enacc_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // a result is never written over one still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_write |-> !(m_tvalid && !m_tready))
        else $error("result overwritten");

    // an empty request that is not last is dropped at once
    a_empty_skip: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser[0] && !s_tlast) |=> s_tready)
        else $error("empty request stalled input");

    // a final empty request starts the root and blocks input
    a_empty_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser[0] && s_tlast) |=> !s_tready)
        else $error("final empty request did not start root");

    // a result appears only after a write
    a_valid_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(cmd.out_write))
        else $error("result valid without write");

endmodule
`default_nettype wire

### design/enacc_ctrl.sv
`default_nettype none
module enacc_ctrl (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     s_tvalid,
    input  wire                     s_tlast,
    input  wire                     s_none,
    output logic                    s_tready,
    output enacc_pkg::enacc_cmd_t   cmd,
    input  enacc_pkg::enacc_stat_t  stat
);
    import enacc_pkg::*;

    localparam int CW = $clog2(SQRT_STEPS);

    typedef enum logic [3:0] {
        S_IDLE, S_NORM, S_MUL, S_MRND, S_ADD, S_ARND,
        S_SPREP, S_SNORM, S_SQINIT, S_SQRT, S_SOUT
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          last_reg, last_next;
    logic          accept;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        cnt_next   = cnt_reg;
        last_next  = last_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    last_next = s_tlast;
                    if (!s_none) begin
                        cmd.load_elem = 1'b1;
                        state_next    = S_NORM;
                    end else if (s_tlast) begin
                        state_next = S_SPREP;
                    end
                end
            end
            S_NORM: begin
                if (stat.spec) begin
                    state_next = S_ADD;
                end else if (stat.man_norm) begin
                    state_next = S_MUL;
                    cnt_next   = '0;
                end else begin
                    cmd.norm_step = 1'b1;
                end
            end
            S_MUL: begin
                cmd.mul_step = 1'b1;
                cmd.mul_sel  = cnt_reg[1:0];
                if (cnt_reg == CW'(MUL_STEPS - 1)) begin
                    state_next = S_MRND;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_MRND: begin
                cmd.mul_round = 1'b1;
                state_next    = S_ADD;
            end
            S_ADD: begin
                cmd.add_op = 1'b1;
                state_next = S_ARND;
            end
            S_ARND: begin
                cmd.add_round = 1'b1;
                state_next    = last_reg ? S_SPREP : S_IDLE;
            end
            S_SPREP: begin
                cmd.sqrt_load = 1'b1;
                state_next    = S_SNORM;
            end
            S_SNORM: begin
                if (stat.spec) begin
                    state_next = S_SOUT;
                end else if (stat.man_norm) begin
                    state_next = S_SQINIT;
                end else begin
                    cmd.norm_step = 1'b1;
                end
            end
            S_SQINIT: begin
                cmd.sqrt_init = 1'b1;
                cnt_next      = '0;
                state_next    = S_SQRT;
            end
            S_SQRT: begin
                cmd.sqrt_step = 1'b1;
                if (cnt_reg == CW'(SQRT_STEPS - 1)) begin
                    state_next = S_SOUT;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_SOUT: begin
                if (!stat.out_busy) begin
                    cmd.out_write = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            last_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            last_reg  <= last_next;
        end
    end

endmodule
`default_nettype wire

### design/enacc_dp.sv
`default_nettype none
module enacc_dp (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire  [enacc_pkg::DW-1:0]     s_tdata,
    input  enacc_pkg::enacc_cmd_t        cmd,
    output enacc_pkg::enacc_stat_t       stat,
    output logic                         m_tvalid,
    input  wire                          m_tready,
    output logic [enacc_pkg::DW-1:0]     m_tdata
);
    import enacc_pkg::*;

    function automatic logic [53:0] rne(input logic [52:0] sig, input logic g,
                                        input logic st);
        return {1'b0, sig} + 54'(g & (st | sig[0]));
    endfunction

    // shared normalizer operand
    logic [53:0]        man_reg, man_next;
    logic signed [12:0] exp_reg, exp_next;
    logic               spec_reg, spec_next;
    logic [63:0]        spec_val_reg, spec_val_next;
    // square
    logic [105:0]       acc_reg, acc_next;
    logic [63:0]        prod_reg, prod_next;
    // accumulate
    logic [63:0]        sum_reg, sum_next;
    logic [56:0]        add_sum_reg, add_sum_next;
    logic [11:0]        add_exp_reg, add_exp_next;
    logic               add_spec_reg, add_spec_next;
    logic [63:0]        add_sval_reg, add_sval_next;
    // square root
    logic [53:0]        rad_reg, rad_next;
    logic [55:0]        rem_reg, rem_next;
    logic [53:0]        q_reg, q_next;
    logic [10:0]        re_reg, re_next;
    logic [63:0]        out_reg, out_next;
    logic               out_valid_reg, out_valid_next;

    // operand unpack
    logic [10:0]        x_expf;
    logic [51:0]        x_frac;
    logic               x_zero, x_infnan, x_nz;
    logic signed [12:0] x_eext;

    // multiplier
    logic [26:0]        mul_a, mul_b;
    logic [53:0]        mprod;

    // product rounding
    logic               m_top, m_g, m_st, m_g2, m_st2, m_lost;
    logic signed [12:0] m_pe, m_sh;
    logic [5:0]         m_shc;
    logic [52:0]        m_sig, m_sig2;
    logic [53:0]        m_v, m_vs, m_rnd, m_rnd2;
    logic [10:0]        m_bexp;

    // adder
    logic [10:0]        a_expf, b_expf, a_e, b_e, big_e, sml_e, d_e;
    logic [52:0]        a_m, b_m, big_m, sml_m;
    logic               a_nan, b_nan;
    logic [5:0]         d_c;
    logic [55:0]        sml_x, sml_sh;
    logic               sml_lost;
    logic               r_c;
    logic [55:0]        r_m;
    logic [11:0]        r_e;
    logic [53:0]        r_rnd;

    // square root
    logic               s_odd, s_ge;
    logic [53:0]        s_m2;
    logic signed [12:0] s_e2, s_se;
    logic [55:0]        s_r2, s_t;
    logic [53:0]        s_q;

    assign x_expf   = cmd.load_elem ? s_tdata[62:52] : sum_reg[62:52];
    assign x_frac   = cmd.load_elem ? s_tdata[51:0]  : sum_reg[51:0];
    assign x_zero   = (x_expf == '0) && (x_frac == '0);
    assign x_infnan = (x_expf == EXP_ALL1);
    assign x_nz     = (x_expf != '0);
    assign x_eext   = $signed({2'b00, x_expf});

    always_comb begin
        mul_a = man_reg[26:0];
        mul_b = man_reg[26:0];
        case (cmd.mul_sel)
            MUL_HL:  mul_a = {1'b0, man_reg[52:27]};
            MUL_HH: begin
                mul_a = {1'b0, man_reg[52:27]};
                mul_b = {1'b0, man_reg[52:27]};
            end
            default: ;
        endcase
    end
    assign mprod = mul_a * mul_b;

    // product round and pack
    always_comb begin
        m_top  = acc_reg[105];
        m_pe   = (exp_reg <<< 1) + 13'(m_top);
        m_sig  = m_top ? acc_reg[105:53] : acc_reg[104:52];
        m_g    = m_top ? acc_reg[52] : acc_reg[51];
        m_st   = m_top ? (|acc_reg[51:0]) : (|acc_reg[50:0]);
        m_rnd  = rne(m_sig, m_g, m_st);
        m_bexp = 11'(m_pe + 13'sd1022);
        // subnormal result: denormalize before rounding
        m_sh   = -13'sd1022 - m_pe;
        m_shc  = (m_sh > 13'sd63) ? 6'd63 : m_sh[5:0];
        m_v    = {m_sig, m_g};
        m_vs   = m_v >> m_shc;
        m_lost = |(m_v & ~({54{1'b1}} << m_shc));
        m_sig2 = m_vs[53:1];
        m_g2   = m_vs[0];
        m_st2  = m_st | m_lost;
        m_rnd2 = rne(m_sig2, m_g2, m_st2);
    end

    // aligned add of two nonnegative values
    always_comb begin
        a_expf   = sum_reg[62:52];
        b_expf   = prod_reg[62:52];
        a_nan    = (a_expf == EXP_ALL1) && (sum_reg[51:0] != '0);
        b_nan    = (b_expf == EXP_ALL1) && (prod_reg[51:0] != '0);
        a_e      = (a_expf == '0) ? 11'd1 : a_expf;
        b_e      = (b_expf == '0) ? 11'd1 : b_expf;
        a_m      = {a_expf != '0, sum_reg[51:0]};
        b_m      = {b_expf != '0, prod_reg[51:0]};
        if (b_e > a_e) begin
            big_e = b_e; big_m = b_m; sml_e = a_e; sml_m = a_m;
        end else begin
            big_e = a_e; big_m = a_m; sml_e = b_e; sml_m = b_m;
        end
        d_e      = big_e - sml_e;
        d_c      = (d_e > 11'd63) ? 6'd63 : d_e[5:0];
        sml_x    = {sml_m, 3'b000};
        sml_sh   = sml_x >> d_c;
        sml_lost = |(sml_x & ~({56{1'b1}} << d_c));
        // carry out of the sum shifts one place right
        r_c      = add_sum_reg[56];
        r_m      = r_c ? {add_sum_reg[56:2], add_sum_reg[1] | add_sum_reg[0]}
                       : add_sum_reg[55:0];
        r_e      = add_exp_reg + 12'(r_c);
        r_rnd    = rne(r_m[55:3], r_m[2], |r_m[1:0]);
    end

    // root recurrence, two radicand bits a step
    always_comb begin
        s_odd = exp_reg[0];
        s_m2  = s_odd ? (man_reg << 1) : man_reg;
        s_e2  = s_odd ? (exp_reg - 13'sd1) : exp_reg;
        s_se  = s_e2 + 13'sd52;
        s_r2  = {rem_reg[53:0], rad_reg[53:52]};
        s_t   = {q_reg, 2'b01};
        s_ge  = (s_r2 >= s_t);
        s_q   = q_reg + 54'(rem_reg > {2'b00, q_reg});
    end

    always_comb begin
        man_next       = man_reg;
        exp_next       = exp_reg;
        spec_next      = spec_reg;
        spec_val_next  = spec_val_reg;
        acc_next       = acc_reg;
        prod_next      = prod_reg;
        sum_next       = sum_reg;
        add_sum_next   = add_sum_reg;
        add_exp_next   = add_exp_reg;
        add_spec_next  = add_spec_reg;
        add_sval_next  = add_sval_reg;
        rad_next       = rad_reg;
        rem_next       = rem_reg;
        q_next         = q_reg;
        re_next        = re_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_tready;

        if (cmd.load_elem) begin
            man_next  = {1'b0, x_nz, x_frac};
            exp_next  = x_nz ? (x_eext - 13'sd1023) : -13'sd1022;
            spec_next = x_zero || x_infnan;
            if (x_infnan) begin
                prod_next = (x_frac != '0) ? QNAN_BITS : INF_BITS;
            end else begin
                prod_next = '0;
            end
        end
        if (cmd.sqrt_load) begin
            man_next      = {1'b0, x_nz, x_frac};
            exp_next      = x_nz ? (x_eext - 13'sd1075) : -13'sd1074;
            spec_next     = x_zero || x_infnan;
            spec_val_next = (x_infnan && (x_frac != '0)) ? QNAN_BITS : sum_reg;
        end
        if (cmd.norm_step) begin
            man_next = man_reg << 1;
            exp_next = exp_reg - 13'sd1;
        end
        if (cmd.mul_step) begin
            case (cmd.mul_sel)
                MUL_LL:  acc_next = 106'(mprod);
                MUL_HL:  acc_next = acc_reg + (106'(mprod) << 28);
                default: acc_next = acc_reg + (106'(mprod) << 54);
            endcase
        end
        if (cmd.mul_round) begin
            if (m_pe > 13'sd1023) begin
                prod_next = INF_BITS;
            end else if (m_pe >= -13'sd1022) begin
                prod_next = {1'b0, m_bexp, 52'b0} + 64'(m_rnd);
            end else begin
                prod_next = 64'(m_rnd2);
            end
        end
        if (cmd.add_op) begin
            add_spec_next = (a_expf == EXP_ALL1) || (b_expf == EXP_ALL1);
            add_sval_next = (a_nan || b_nan) ? QNAN_BITS : INF_BITS;
            add_sum_next  = {1'b0, big_m, 3'b000}
                          + {1'b0, sml_sh[55:1], sml_sh[0] | sml_lost};
            add_exp_next  = {1'b0, big_e};
        end
        if (cmd.add_round) begin
            if (add_spec_reg) begin
                sum_next = add_sval_reg;
            end else if (r_e >= 12'd2047) begin
                sum_next = INF_BITS;
            end else begin
                sum_next = {1'b0, 11'(r_e - 12'd1), 52'b0} + 64'(r_rnd);
            end
        end
        if (cmd.sqrt_init) begin
            rad_next = s_m2;
            rem_next = '0;
            q_next   = '0;
            re_next  = 11'((s_se >>> 1) + 13'sd1023);
        end
        if (cmd.sqrt_step) begin
            rem_next = s_ge ? (s_r2 - s_t) : s_r2;
            q_next   = {q_reg[52:0], s_ge};
            rad_next = rad_reg << 2;
        end
        if (cmd.out_write) begin
            out_next       = spec_reg ? spec_val_reg
                                      : ({1'b0, re_reg - 11'd1, 52'b0} + 64'(s_q));
            out_valid_next = 1'b1;
            sum_next       = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        man_reg      <= man_next;
        exp_reg      <= exp_next;
        spec_reg     <= spec_next;
        spec_val_reg <= spec_val_next;
        acc_reg      <= acc_next;
        prod_reg     <= prod_next;
        add_sum_reg  <= add_sum_next;
        add_exp_reg  <= add_exp_next;
        add_spec_reg <= add_spec_next;
        add_sval_reg <= add_sval_next;
        rad_reg      <= rad_next;
        rem_reg      <= rem_next;
        q_reg        <= q_next;
        re_reg       <= re_next;
        out_reg      <= out_next;
    end

    assign stat.man_norm = man_reg[52];
    assign stat.spec     = spec_reg;
    assign stat.out_busy = out_valid_reg && !m_tready;
    assign m_tvalid      = out_valid_reg;
    assign m_tdata       = out_reg;

endmodule
`default_nettype wire
